// ----- hw/rtl/cnra_pkg.sv -----
// Shared constants, payload structs and pipeline structs for the centre-nearest run allocator.
// No dependencies; every other file of the block imports this package.
package cnra_pkg;

    localparam int MAX_SIDE = 64;
    localparam int ROW_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int LEN_W    = 7;
    localparam int CFG_W    = 7;
    localparam int COORD_W  = 7;
    localparam int HL_W     = $clog2(ROW_W + 1);
    localparam int C0_W     = SIDE_W + 1;
    localparam int COST_W   = 2 * SIDE_W;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef logic [MAX_SIDE-1:0] t_row_bits;

    typedef struct packed {
        logic             req_type;
        logic [LEN_W-1:0] run_length;
    } t_req;

    typedef struct packed {
        logic               granted;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] first_col;
        logic [COORD_W-1:0] last_col;
    } t_rsp;

    // Per-request values held constant while the rows are scanned.
    typedef struct packed {
        logic [SIDE_W-1:0]      side;
        logic [LEN_W-1:0]       len;
        logic [HL_W-1:0]        hlog;
        logic [ROW_W-1:0]       sh;
        logic [SIDE_W-1:0]      k;
        logic signed [C0_W-1:0] c0;
    } t_ctx;

    // Best run found in one row.
    typedef struct packed {
        logic              vld;
        logic              found;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [COST_W-1:0] cost;
    } t_row_res;

endpackage

// ----- hw/rtl/center_nearest_run_allocator.sv -----
// Centre-nearest run allocator, top level: request sequencer, best-run tracking,
// write-back and output register. Depends on cnra_pkg, cnra_row_mem, cnra_row_eval.
//
// The block keeps a square occupancy map, one bitmap row per memory entry, and answers
// each transaction with exactly one result. An allocate scans the rows in use one per
// cycle through a five-stage evaluator that finds, for each row, the free run of the
// requested length closest to the centre; the cheapest run overall (first in row-major
// order on a tie) is then read back, marked occupied and written. The length of an
// allocate's scan is set by the single read port of the occupancy memory, which
// delivers one row per cycle. A clear, or an allocate that is rejected at once (length
// zero or longer than the grid), skips the scan and goes straight to the result; the
// clear drops every row's valid bit at once. The block works on one transaction at a
// time but takes the next one while the previous result still waits in the output
// register. The grid size register may be written only while idle.
module center_nearest_run_allocator
    import cnra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_req             i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_rsp             o_out_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_DRAIN  = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_RDBK   = 7'b0010000,
        ST_WRBK   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_grid;
    t_ctx              r_ctx, n_ctx;
    logic [ROW_W-1:0]  r_scan_row;
    logic              r_s0_vld;
    logic [ROW_W-1:0]  r_s0_row;
    logic              r_best_found;
    logic [ROW_W-1:0]  r_best_row, r_best_col;
    logic [COST_W-1:0] r_best_cost;
    t_rsp              r_res, n_res;
    logic              r_out_vld;
    t_rsp              r_out;

    logic              in_acc, res_load;
    logic [SIDE_W-1:0] side_eff;
    logic [ROW_W-1:0]  last_row;
    logic              mem_rd_en, mem_wr_en, mem_clr;
    logic [ROW_W-1:0]  mem_rd_addr;
    t_row_bits         mem_rd_data, mem_wr_data, run_mask;
    t_row_res          row_res;

    cnra_row_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_best_row),
        .i_wr_data (mem_wr_data),
        .i_clr     (mem_clr)
    );

    cnra_row_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctx   (r_ctx),
        .i_vld   (r_s0_vld),
        .i_row   (r_s0_row),
        .i_data  (mem_rd_data),
        .o_res   (row_res)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign side_eff   = (r_grid > CFG_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(r_grid);
    assign last_row   = ROW_W'(r_ctx.side - SIDE_W'(1));

    // Request constants: the longest power of two within the length, the remaining
    // shift, the centre, and the lowest start whose window is centred best.
    always_comb begin
        n_ctx.side = side_eff;
        n_ctx.len  = i_in_req.run_length;
        n_ctx.hlog = '0;
        for (int i = 1; i <= ROW_W; i++) begin
            if ((i_in_req.run_length >> i) != '0) begin
                n_ctx.hlog = HL_W'(i);
            end
        end
        n_ctx.sh = ROW_W'(i_in_req.run_length - (LEN_W'(1) << n_ctx.hlog));
        n_ctx.k  = (side_eff + SIDE_W'(1)) >> 1;
        n_ctx.c0 = $signed({1'b0, n_ctx.k}) - $signed(C0_W'(1))
                   - $signed({1'b0, SIDE_W'(i_in_req.run_length >> 1)});
    end

    assign mem_rd_en   = (r_state == ST_SCAN) || (r_state == ST_RDBK);
    assign mem_rd_addr = (r_state == ST_SCAN) ? r_scan_row : r_best_row;
    assign run_mask    = ({MAX_SIDE{1'b1}} >> ROW_W'(SIDE_W'(MAX_SIDE) - SIDE_W'(r_ctx.len)))
                         << r_best_col;
    assign mem_wr_data = mem_rd_data | run_mask;
    assign mem_wr_en   = (r_state == ST_WRBK);
    assign mem_clr     = in_acc && (i_in_req.req_type == REQ_CLEAR);
    assign res_load    = (r_state == ST_FINISH) && (!r_out_vld || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    if (i_in_req.req_type == REQ_CLEAR) begin
                        n_res.granted = 1'b1;
                        n_state       = ST_FINISH;
                    end else if (i_in_req.run_length == '0
                                 || SIDE_W'(i_in_req.run_length) > side_eff
                                 || i_in_req.run_length > LEN_W'(MAX_SIDE)) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_scan_row == last_row) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (row_res.vld && row_res.row == last_row) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = r_best_found ? ST_RDBK : ST_FINISH;
            end
            ST_RDBK: begin
                n_state = ST_WRBK;
            end
            ST_WRBK: begin
                n_res.granted   = 1'b1;
                n_res.row       = COORD_W'(r_best_row) + COORD_W'(1);
                n_res.first_col = COORD_W'(r_best_col) + COORD_W'(1);
                n_res.last_col  = COORD_W'(r_best_col) + COORD_W'(r_ctx.len);
                n_state         = ST_FINISH;
            end
            ST_FINISH: begin
                if (res_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_s0_row <= r_scan_row;
        if (in_acc) begin
            r_ctx <= n_ctx;
        end
        if (res_load) begin
            r_out <= r_res;
        end
        // Rows arrive in ascending order, so a strict compare keeps the first on a tie.
        if (row_res.vld && row_res.found
            && (!r_best_found || row_res.cost < r_best_cost)) begin
            r_best_row  <= row_res.row;
            r_best_col  <= row_res.col;
            r_best_cost <= row_res.cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_grid       <= CFG_W'(MAX_SIDE);
            r_scan_row   <= '0;
            r_s0_vld     <= 1'b0;
            r_best_found <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s0_vld <= (r_state == ST_SCAN);
            if (i_cfg_we) begin
                r_grid <= i_cfg_data;
            end
            if (in_acc) begin
                r_scan_row   <= '0;
                r_best_found <= 1'b0;
            end else begin
                if (r_state == ST_SCAN) begin
                    r_scan_row <= r_scan_row + ROW_W'(1);
                end
                if (row_res.vld && row_res.found) begin
                    r_best_found <= 1'b1;
                end
            end
            if (res_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

`ifndef SYNTHESIS
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_DRAIN) |-> !mem_wr_en)
        else $error("occupancy written during a scan");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("second transaction taken before the first finished");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_rsp.granted) |->
        (o_out_rsp.row == '0 && o_out_rsp.first_col == '0 && o_out_rsp.last_col == '0))
        else $error("failed result carries coordinates");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.granted && o_out_rsp.row != '0) |->
        (o_out_rsp.last_col >= o_out_rsp.first_col && o_out_rsp.first_col != '0))
        else $error("granted run has a bad column span");
`endif

endmodule

// ----- hw/rtl/cnra_row_mem.sv -----
// Occupancy memory: one row bitmap per entry, registered read, one write port.
// Per-row valid bits let a clear empty every row at once. Depends on cnra_pkg.
module cnra_row_mem
    import cnra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [ROW_W-1:0] i_rd_addr,
    output t_row_bits        o_rd_data,
    input  logic             i_wr_en,
    input  logic [ROW_W-1:0] i_wr_addr,
    input  t_row_bits        i_wr_data,
    input  logic             i_clr
);

    t_row_bits             r_mem [MAX_SIDE];
    logic [MAX_SIDE-1:0]   r_row_vld;
    t_row_bits             r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    // A row never written since the last clear reads as all free.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- hw/rtl/cnra_row_eval.sv -----
// Five-stage row evaluator: free-window map, nearest candidates either side of the
// optimum, their costs, and the row's best run. Depends on cnra_pkg.
module cnra_row_eval
    import cnra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctx             i_ctx,
    input  logic             i_vld,
    input  logic [ROW_W-1:0] i_row,
    input  t_row_bits        i_data,
    output t_row_res         o_res
);

    // Sum of |y - k| over one side of the centre, signed so that a window lying
    // wholly on one side subtracts the part it does not cover.
    function automatic logic signed [COST_W-1:0] f_half(input logic signed [C0_W:0] x);
        logic [SIDE_W-1:0]   n;
        logic [COST_W-1:0]   t;
        begin
            n = (x >= 0) ? SIDE_W'(x) : SIDE_W'(-x - 1);
            t = COST_W'((COST_W'(n) * COST_W'(n + SIDE_W'(1))) >> 1);
            f_half = (x >= 0) ? $signed(t) : -$signed(t);
        end
    endfunction

    logic             r1_vld, r2_vld, r3_vld, r4_vld;
    logic [ROW_W-1:0] r1_row, r2_row, r3_row, r4_row;
    t_row_bits        r1_ph, r2_w;
    logic             r3_lf, r3_rf, r4_lf, r4_rf;
    logic [ROW_W-1:0] r3_lc, r3_rc, r4_lc, r4_rc;
    logic signed [COST_W-1:0] r4_fl, r4_fr;
    logic [COST_W-1:0] r4_rowterm;
    logic              r5_vld, r5_found;
    logic [ROW_W-1:0]  r5_row, r5_col;
    logic [COST_W-1:0] r5_cost;

    t_row_bits        free_bits, ph, w_bits, wl, wr;
    logic             lf, rf;
    logic [ROW_W-1:0] lc, rc;
    logic signed [C0_W:0] xl1, xl2, xr1, xr2;
    logic [SIDE_W-1:0] dr;
    logic [COST_W-1:0] cost_l, cost_r;

    // Stage 1: free cells inside the grid, then runs of 2**hlog free cells.
    always_comb begin
        for (int j = 0; j < MAX_SIDE; j++) begin
            free_bits[j] = !i_data[j] && (SIDE_W'(j) < i_ctx.side);
        end
        ph = free_bits;
        for (int i = 0; i < ROW_W; i++) begin
            if (HL_W'(i) < i_ctx.hlog) begin
                ph = ph & (ph >> (1 << i));
            end
        end
    end

    // Stage 2: two overlapping power-of-two windows cover any length.
    assign w_bits = r1_ph & (r1_ph >> i_ctx.sh);

    // Stage 3: nearest free window at or left of the optimum and right of it.
    always_comb begin
        for (int j = 0; j < MAX_SIDE; j++) begin
            wl[j] = r2_w[j] && ($signed(C0_W'(j)) <= i_ctx.c0);
            wr[j] = r2_w[j] && ($signed(C0_W'(j)) >  i_ctx.c0);
        end
        lf = 1'b0;
        lc = '0;
        for (int j = 0; j < MAX_SIDE; j++) begin
            if (wl[j]) begin
                lf = 1'b1;
                lc = ROW_W'(j);
            end
        end
        rf = 1'b0;
        rc = '0;
        for (int j = MAX_SIDE - 1; j >= 0; j--) begin
            if (wr[j]) begin
                rf = 1'b1;
                rc = ROW_W'(j);
            end
        end
    end

    // Stage 4 operands: first cell a = c+1, last cell b = c+len, one-based.
    always_comb begin
        xl1 = $signed({2'b00, i_ctx.k}) - $signed({1'b0, 1'b0, 1'b0, r3_lc} + (C0_W+1)'(1));
        xl2 = $signed({2'b00, SIDE_W'(r3_lc)}) + $signed({2'b00, i_ctx.len})
              - $signed({2'b00, i_ctx.k});
        xr1 = $signed({2'b00, i_ctx.k}) - $signed({1'b0, 1'b0, 1'b0, r3_rc} + (C0_W+1)'(1));
        xr2 = $signed({2'b00, SIDE_W'(r3_rc)}) + $signed({2'b00, i_ctx.len})
              - $signed({2'b00, i_ctx.k});
        dr  = ({1'b0, r3_row} + SIDE_W'(1) > i_ctx.k) ?
              ({1'b0, r3_row} + SIDE_W'(1) - i_ctx.k) : (i_ctx.k - {1'b0, r3_row} - SIDE_W'(1));
    end

    // Stage 5: total cost, ties to the lower column.
    always_comb begin
        cost_l = r4_rowterm + COST_W'(r4_fl);
        cost_r = r4_rowterm + COST_W'(r4_fr);
    end

    always_ff @(posedge i_clk) begin
        r1_ph      <= ph;
        r1_row     <= i_row;
        r2_w       <= w_bits;
        r2_row     <= r1_row;
        r3_lf      <= lf;
        r3_rf      <= rf;
        r3_lc      <= lc;
        r3_rc      <= rc;
        r3_row     <= r2_row;
        r4_fl      <= f_half(xl1) + f_half(xl2);
        r4_fr      <= f_half(xr1) + f_half(xr2);
        r4_rowterm <= COST_W'(i_ctx.len) * COST_W'(dr);
        r4_lf      <= r3_lf;
        r4_rf      <= r3_rf;
        r4_lc      <= r3_lc;
        r4_rc      <= r3_rc;
        r4_row     <= r3_row;
        r5_row     <= r4_row;
        if (r4_lf && (!r4_rf || cost_l <= cost_r)) begin
            r5_found <= 1'b1;
            r5_col   <= r4_lc;
            r5_cost  <= cost_l;
        end else begin
            r5_found <= r4_rf;
            r5_col   <= r4_rc;
            r5_cost  <= cost_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    assign o_res = '{vld: r5_vld, found: r5_found, row: r5_row, col: r5_col, cost: r5_cost};

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for center_nearest_run_allocator: drives allocate and clear
// transactions under random idling and checks every result against a local predictor.
// Depends on cnra_pkg and the allocator RTL.
module tb;
    import cnra_pkg::*;

    // Clock, reset and block ports.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_req i_in_req = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_rsp;
    logic i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    center_nearest_run_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_req(i_in_req),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_rsp(o_out_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // Predictor state: its own copy of the seat map and of the grid size register.
    logic [MAX_SIDE-1:0] seat_map [MAX_SIDE];
    logic [CFG_W-1:0]    grid_reg;

    t_req pending_reqs [$];   // transactions waiting to be offered by the driver
    t_rsp expected_rsps [$];  // results predicted for accepted transactions

    int  mismatches = 0;
    int  cycles = 0;
    bit  out_idle_off = 1'b0;  // no receiver idling in the last part of the run
    bit  in_idle_off = 1'b0;
    int  hold_cycles = 0;      // a long receiver hold-off, set by the initial block
    int  in_gap = 0;
    int  out_gap = 0;
    bit  sender_pause = 1'b0;  // driver offers nothing while this is set

    // Acceptance seen at the rising edge, kept for the driver at the next falling edge.
    logic o_in_ready_q = 1'b0;

    // Works out the seat run granted for one request and updates the seat map; a clear empties the map.
    function automatic t_rsp allocate_seats(t_req rq);
        t_rsp r;
        int side, centre, len, cost, best_cost, best_r, best_c;
        bit found, free;
        r = '0;
        found = 0;
        best_cost = 0;
        best_r = 0;
        best_c = 0;
        side = (grid_reg > MAX_SIDE) ? MAX_SIDE : grid_reg;
        centre = (side + 1) / 2;
        len = rq.run_length;
        if (rq.req_type == REQ_CLEAR) begin
            for (int i = 0; i < MAX_SIDE; i++) seat_map[i] = '0;
            r.granted = 1'b1;
            return r;
        end
        if (len == 0 || len > side) return r;
        for (int y = 0; y < side; y++) begin
            for (int x = 0; x + len <= side; x++) begin
                free = 1;
                cost = 0;
                for (int k = x; k < x + len; k++) begin
                    if (seat_map[y][k]) free = 0;
                    cost += ((y + 1 > centre) ? y + 1 - centre : centre - y - 1)
                          + ((k + 1 > centre) ? k + 1 - centre : centre - k - 1);
                end
                if (free && (!found || cost < best_cost)) begin
                    found = 1;
                    best_cost = cost;
                    best_r = y;
                    best_c = x;
                end
            end
        end
        if (!found) return r;
        for (int k = best_c; k < best_c + len; k++) seat_map[best_r][k] = 1'b1;
        r.granted = 1'b1;
        r.row = COORD_W'(best_r + 1);
        r.first_col = COORD_W'(best_c + 1);
        r.last_col = COORD_W'(best_c + len);
        return r;
    endfunction

    // Driver: offers the next pending transaction at the falling edge, with random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready_q) begin
                // The last offer was accepted at the rising edge just gone.
                if (pending_reqs.size() > 0 && !sender_pause && in_gap == 0 &&
                    (in_idle_off || $urandom_range(0, 9) != 0)) begin
                    i_in_req <= pending_reqs.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                    if (!in_idle_off && $urandom_range(0, 3) == 0)
                        in_gap = $urandom_range(1, 14);
                end
            end else if (!i_in_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_reqs.size() > 0 && !sender_pause) begin
                    i_in_valid <= 1'b1;
                    i_in_req <= pending_reqs.pop_front();
                end
            end
        end
    end

    // Receiver: long hold-off first, then random bursts of idling.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else if (!out_idle_off && $urandom_range(0, 11) == 0) begin
                out_gap = $urandom_range(0, 13);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted result.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        o_in_ready_q <= o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                expected_rsps.push_back(allocate_seats(i_in_req));
            if (o_out_valid && i_out_ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", o_out_rsp);
                end else begin
                    t_rsp e;
                    e = expected_rsps.pop_front();
                    if (e.granted !== o_out_rsp.granted || e.row !== o_out_rsp.row ||
                        e.first_col !== o_out_rsp.first_col ||
                        e.last_col !== o_out_rsp.last_col) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", e, o_out_rsp);
                    end
                end
            end
        end
        if (cycles > 400000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_req(input logic kind, input int len);
        t_req q;
        q.req_type = kind;
        q.run_length = LEN_W'(len);
        pending_reqs.push_back(q);
    endtask

    // Waits until everything queued is accepted and answered, then lets the block settle.
    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_grid(input int g);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= CFG_W'(g);
        grid_reg = CFG_W'(g);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Queues a random batch: mostly short runs that fit, some full-width and random-length ones, and clears.
    task automatic random_batch(input int n, input int g);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) queue_req(REQ_CLEAR, $urandom_range(0, 127));
            else if (pick < 10) queue_req(REQ_ALLOC, $urandom_range(0, 127));
            else if (pick < 14) queue_req(REQ_ALLOC, g);
            else queue_req(REQ_ALLOC, $urandom_range(1, (g < 6) ? g : 6));
        end
    endtask

    int sizes [6] = '{64, 1, 2, 7, 13, 127};

    initial begin
        for (int i = 0; i < MAX_SIDE; i++) seat_map[i] = '0;
        grid_reg = 7'd64;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset grid size of 64.
        queue_req(REQ_ALLOC, 0);
        queue_req(REQ_ALLOC, 64);
        queue_req(REQ_ALLOC, 65);
        queue_req(REQ_ALLOC, 127);
        queue_req(REQ_ALLOC, 1);
        queue_req(REQ_ALLOC, 1);
        queue_req(REQ_ALLOC, 3);
        queue_req(REQ_ALLOC, 32);
        queue_req(REQ_CLEAR, 127);
        queue_req(REQ_ALLOC, 5);
        drain();
        // Smallest grid: fill it, then find no free run, then grid size zero.
        set_grid(1);
        queue_req(REQ_ALLOC, 1);
        queue_req(REQ_ALLOC, 1);
        queue_req(REQ_ALLOC, 2);
        drain();
        set_grid(0);
        queue_req(REQ_ALLOC, 1);
        queue_req(REQ_CLEAR, 0);
        drain();
        // Above the maximum side: saturates; old bits outside a smaller grid persist.
        set_grid(127);
        queue_req(REQ_ALLOC, 64);
        queue_req(REQ_ALLOC, 63);
        drain();
        set_grid(3);
        queue_req(REQ_ALLOC, 3);
        queue_req(REQ_ALLOC, 3);
        queue_req(REQ_ALLOC, 3);
        queue_req(REQ_ALLOC, 1);
        queue_req(REQ_CLEAR, 0);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        set_grid(4);
        hold_cycles = 300;
        random_batch(20, 4);
        drain();

        // Random phases over several grid sizes; small grids keep transactions short.
        foreach (sizes[s]) begin
            set_grid(sizes[s]);
            random_batch(sizes[s] >= 64 ? 20 : 60, (sizes[s] > 64) ? 64 : sizes[s]);
            drain();
        end
        // Sender pause until every result has come, then a run with no idling at all.
        set_grid(5);
        random_batch(40, 5);
        repeat (150) @(posedge i_clk);
        sender_pause = 1'b1;
        while (expected_rsps.size() > 0 || i_in_valid) @(posedge i_clk);
        sender_pause = 1'b0;
        drain();
        out_idle_off = 1'b1;
        in_idle_off = 1'b1;
        set_grid(8);
        random_batch(88, 8);
        drain();

        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
